FILE: src/msbfr_pkg.sv
// ----------------------------------------------------------------------------
// msbfr_pkg: shared definitions for the MSB-first bit field reader
// Sizes, command and status codes, and the controller/datapath bundles.
// ----------------------------------------------------------------------------
package msbfr_pkg;

  localparam int BUF_DEPTH = 4096;
  localparam int ADDR_W    = $clog2(BUF_DEPTH);
  localparam int LEN_W     = ADDR_W + 1;
  localparam int MAX_BITS  = 24;
  localparam int CNT_W     = 5;
  localparam int VAL_W     = 24;

  localparam logic [1:0] CMD_PUSH    = 2'd0;
  localparam logic [1:0] CMD_READ    = 2'd1;
  localparam logic [1:0] CMD_RESTART = 2'd2;

  localparam logic [1:0] ST_FULL  = 2'd0;
  localparam logic [1:0] ST_TRUNC = 2'd1;
  localparam logic [1:0] ST_END   = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic push;
    logic restart;
    logic rd_start;
    logic step;
    logic load_out;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic imm;        // read request answered without touching the store
    logic step_last;  // the current step finishes the read
    logic out_free;   // result register can take a new result
  } dp_stat_t;

endpackage

FILE: src/msbfr_ctrl.sv
// ----------------------------------------------------------------------------
// msbfr_ctrl: sequencer of the bit field reader
// Accepts requests, walks a read through the store one byte per cycle and
// hands the result to the output register.
// ----------------------------------------------------------------------------
module msbfr_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [1:0]          in_cmd,
  output logic                in_ready,
  input  msbfr_pkg::dp_stat_t stat,
  output msbfr_pkg::dp_cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_STEP,
    S_FIN
  } state_t;

  state_t state_r;
  state_t state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (in_cmd)
            msbfr_pkg::CMD_PUSH:    cmd.push = 1'b1;
            msbfr_pkg::CMD_RESTART: cmd.restart = 1'b1;
            msbfr_pkg::CMD_READ: begin
              cmd.rd_start = 1'b1;
              state_nxt    = stat.imm ? S_FIN : S_STEP;
            end
            default: ;
          endcase
        end
      end
      S_STEP: begin
        cmd.step = 1'b1;
        if (stat.step_last) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: src/msbfr_dp.sv
// ----------------------------------------------------------------------------
// msbfr_dp: datapath of the bit field reader
// Byte store, read position, bit accumulator and the result register.
// ----------------------------------------------------------------------------
module msbfr_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  msbfr_pkg::dp_cmd_t                cmd,
  output msbfr_pkg::dp_stat_t               stat,
  input  logic [7:0]                        in_byte_value,
  input  logic [msbfr_pkg::CNT_W-1:0]       in_bit_count,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [msbfr_pkg::VAL_W-1:0]       out_field_value,
  output logic [1:0]                        out_read_status
);

  localparam int LEN_W  = msbfr_pkg::LEN_W;
  localparam int ADDR_W = msbfr_pkg::ADDR_W;
  localparam int CNT_W  = msbfr_pkg::CNT_W;
  localparam int VAL_W  = msbfr_pkg::VAL_W;

  logic [7:0]       mem [msbfr_pkg::BUF_DEPTH];
  logic [7:0]       rdata_r;
  logic [ADDR_W-1:0] raddr;
  logic             rd_en;

  logic [LEN_W-1:0] len_r;
  logic [LEN_W-1:0] pos_r;
  logic [2:0]       bit_r;
  logic             end_r;
  logic [CNT_W-1:0] need_r;
  logic [VAL_W-1:0] acc_r;
  logic [1:0]       res_st_r;

  logic             out_valid_r;
  logic [VAL_W-1:0] out_value_r;
  logic [1:0]       out_status_r;

  logic [CNT_W-1:0] need_clamp;
  logic             imm_zero;
  logic             imm_end;
  logic [LEN_W-1:0] pos_inc;
  logic [3:0]       avail;
  logic             take;
  logic [CNT_W-1:0] need_left;
  logic             last_byte;
  logic [3:0]       shamt;
  logic [3:0]       rsh;
  logic [7:0]       field8;
  logic [VAL_W-1:0] acc_nxt;
  logic             full;

  assign need_clamp = (in_bit_count > CNT_W'(msbfr_pkg::MAX_BITS))
                      ? CNT_W'(msbfr_pkg::MAX_BITS) : in_bit_count;
  assign imm_zero   = (need_clamp == '0);
  assign imm_end    = end_r || (pos_r >= len_r);
  assign full       = (len_r >= LEN_W'(msbfr_pkg::BUF_DEPTH));
  assign pos_inc    = pos_r + {{(LEN_W-1){1'b0}}, 1'b1};

  // One byte of the current read: either the rest of the byte or the
  // leading part of what remains in it.
  assign avail     = 4'd8 - {1'b0, bit_r};
  assign take      = (need_r >= {1'b0, avail});
  assign need_left = need_r - {1'b0, avail};
  assign last_byte = (pos_inc >= len_r);
  assign rsh       = avail - need_r[3:0];
  assign shamt     = take ? avail : need_r[3:0];
  assign field8    = take ? (rdata_r & (8'hFF >> bit_r))
                          : ((rdata_r >> rsh) & (8'hFF >> (4'd8 - need_r[3:0])));
  assign acc_nxt   = (acc_r << shamt) | {{(VAL_W-8){1'b0}}, field8};

  assign stat.imm       = imm_zero || imm_end;
  assign stat.step_last = !take || last_byte || (need_left == '0);
  assign stat.out_free  = !out_valid_r || out_ready;

  // The next byte is fetched while the current one is consumed.
  assign rd_en = (cmd.rd_start && !imm_zero && !imm_end) || cmd.step;
  assign raddr = cmd.step ? pos_inc[ADDR_W-1:0] : pos_r[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.push && !full) begin
      mem[len_r[ADDR_W-1:0]] <= in_byte_value;
    end
    if (rd_en) begin
      rdata_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= '0;
      pos_r       <= '0;
      bit_r       <= '0;
      end_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.push && !full) begin
        len_r <= len_r + {{(LEN_W-1){1'b0}}, 1'b1};
      end
      if (cmd.restart) begin
        len_r <= '0;
        pos_r <= '0;
        bit_r <= '0;
        end_r <= 1'b0;
      end
      if (cmd.step) begin
        if (take) begin
          pos_r <= pos_inc;
          bit_r <= '0;
          if (last_byte) begin
            end_r <= 1'b1;
          end
        end else begin
          bit_r <= bit_r + need_r[2:0];
        end
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_start) begin
      acc_r    <= '0;
      need_r   <= need_clamp;
      res_st_r <= (!imm_zero && imm_end) ? msbfr_pkg::ST_END : msbfr_pkg::ST_FULL;
    end
    if (cmd.step) begin
      acc_r  <= acc_nxt;
      need_r <= take ? need_left : '0;
      if (take && last_byte && (need_left != '0)) begin
        res_st_r <= msbfr_pkg::ST_TRUNC;
      end
    end
    if (cmd.load_out) begin
      out_value_r  <= acc_r;
      out_status_r <= res_st_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_field_value = out_value_r;
  assign out_read_status = out_status_r;

endmodule

FILE: src/msb_first_bit_field_reader.sv
// ----------------------------------------------------------------------------
// msb_first_bit_field_reader: MSB-first bit field reader over a byte store
//
// Input channel (in_valid/in_ready): in_cmd selects push, read or restart.
// A push appends in_byte_value to a 4096-byte store (ignored when full); a
// restart empties the store and rewinds the read position. Neither gives a
// result. A read returns in_bit_count bits (clamped to 24) on the result
// channel (out_valid/out_ready) as out_field_value with out_read_status:
// full, truncated at the end of the data, or already at end.
// A read is accepted, then walks the stored bytes it touches (one to four,
// set by the single read port of the byte store) one byte per cycle in
// S_STEP, then loads the result register in S_FIN once it is free;
// zero-bit reads and reads at the end skip S_STEP. The next request is
// accepted in the cycle after the result register is loaded.
// The result register lets a new request in while a result waits; when
// the receiver stalls, a second read finishes and then holds until the
// register frees. Reset empties the store and clears the position and the
// end flag; no clearing pass is needed.
// ----------------------------------------------------------------------------
module msb_first_bit_field_reader (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  in_cmd,
  input  logic [7:0]                  in_byte_value,
  input  logic [msbfr_pkg::CNT_W-1:0] in_bit_count,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [msbfr_pkg::VAL_W-1:0] out_field_value,
  output logic [1:0]                  out_read_status
);

  msbfr_pkg::dp_cmd_t  cmd;
  msbfr_pkg::dp_stat_t stat;

  msbfr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_cmd   (in_cmd),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  msbfr_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_byte_value   (in_byte_value),
    .in_bit_count    (in_bit_count),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_field_value (out_field_value),
    .out_read_status (out_read_status)
  );

endmodule
